// ===== rtl/lbsc_pkg.sv =====
// Shared types, constants and register codes for the line band steering classifier.
// No dependencies; every other file imports this package.
package lbsc_pkg;

	// Frame size limits and the widths that follow from them
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
	localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);

	// Register fields
	localparam int CFG_W      = 11;
	localparam int THR_W      = 8;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 4;
	localparam int EW_W       = (WIDTH_W > CFG_W) ? WIDTH_W : CFG_W;
	localparam int EH_W       = (HEIGHT_W > CFG_W) ? HEIGHT_W : CFG_W;
	localparam int MIN_WIDTH  = 3;
	localparam int MIN_HEIGHT = 2;

	// Reset values of the registers and of the derived geometry
	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;
	localparam int RST_THRESHOLD    = 60;
	localparam int RST_W_EFF  = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
	localparam int RST_H_EFF  = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
	localparam int RST_BAND   = RST_W_EFF / 3;
	localparam int RST_HALF   = RST_H_EFF / 2;

	// Divide by three as a reciprocal multiply; exact for w < 2^(DIV3_SHIFT-1)
	localparam int DIV3_SHIFT = WIDTH_W + 1;
	localparam int DIV3_RECIP = ((1 << DIV3_SHIFT) + 2) / 3;

	// Luma weights (sum to 2^14) and rounding
	localparam int PIX_W      = 8;
	localparam int LUMA_SHIFT = 14;
	localparam int LUMA_SUM_W = 22;
	localparam int W_BLUE     = 1868;
	localparam int W_GREEN    = 9617;
	localparam int W_RED      = 4899;
	localparam int LUMA_ROUND = 8192;

	// Dark pixel totals
	localparam int COUNT_W = 18;

	typedef logic [COL_W-1:0]    col_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [WIDTH_W-1:0]  width_t;
	typedef logic [HEIGHT_W-1:0] height_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [PIX_W-1:0]    pix_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_DARK_THRESHOLD = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		STEER_NONE    = 3'd0,
		STEER_FORWARD = 3'd1,
		STEER_RIGHT   = 3'd2,
		STEER_LEFT    = 3'd3,
		STEER_STOP    = 3'd4
	} steer_t;

	typedef enum logic [1:0] {
		BAND_OFF    = 2'd0,
		BAND_LEFT   = 2'd1,
		BAND_CENTRE = 2'd2,
		BAND_RIGHT  = 2'd3
	} band_t;

	// Effective geometry, worked out when a register is written
	typedef struct packed {
		width_t        w_eff;
		height_t       h_eff;
		width_t        band1;
		width_t        band2;
		width_t        band3;
		height_t       half1;
		height_t       half2;
		logic [THR_W-1:0] threshold;
	} cfg_t;

	// Pixel held in the input register, already placed in a band
	typedef struct packed {
		logic  valid;
		logic  last;
		band_t band;
		pix_t  blue;
		pix_t  green;
		pix_t  red;
	} s1_t;

	// Pixel after the luma stage: band is off unless it is dark and counted
	typedef struct packed {
		logic  valid;
		logic  last;
		band_t band;
	} s2_t;

endpackage

// ===== rtl/lbsc_pixel_if.sv =====
// Pixel channel: valid/ready handshake with a BGR pixel and end of frame mark.
// Depends on lbsc_pkg.
interface lbsc_pixel_if import lbsc_pkg::*; ();
	logic valid;
	logic ready;
	pix_t blue;
	pix_t green;
	pix_t red;
	logic frame_last;

	modport source (output valid, blue, green, red, frame_last, input ready);
	modport sink   (input valid, blue, green, red, frame_last, output ready);
endinterface

// ===== rtl/lbsc_result_if.sv =====
// Result channel: valid/ready handshake with steering command and band counts.
// Depends on lbsc_pkg.
interface lbsc_result_if import lbsc_pkg::*; ();
	logic   valid;
	logic   ready;
	steer_t steer;
	count_t left_count;
	count_t centre_count;
	count_t right_count;

	modport source (output valid, steer, left_count, centre_count, right_count, input ready);
	modport sink   (input valid, steer, left_count, centre_count, right_count, output ready);
endinterface

// ===== rtl/lbsc_cfg.sv =====
// APB register file: frame width, frame height, dark threshold, plus derived geometry.
// Depends on lbsc_pkg.
module lbsc_cfg import lbsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [THR_W-1:0] threshold_q;
	cfg_t             geom_q;

	reg_idx_t         idx;
	logic             wr_en;
	logic [EW_W-1:0]  w_ext;
	logic [EH_W-1:0]  h_ext;
	width_t           w_new;
	height_t          h_new;
	logic [EW_W+DIV3_SHIFT-1:0] div_prod;
	width_t           band_new;
	height_t          half_new;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// saturate the written value to the supported frame size
	always_comb begin
		w_ext = EW_W'(pwdata[CFG_W-1:0]);
		if (w_ext < EW_W'(MIN_WIDTH))
			w_ext = EW_W'(MIN_WIDTH);
		else if (w_ext > EW_W'(MAX_WIDTH))
			w_ext = EW_W'(MAX_WIDTH);
		w_new = WIDTH_W'(w_ext);

		h_ext = EH_W'(pwdata[CFG_W-1:0]);
		if (h_ext < EH_W'(MIN_HEIGHT))
			h_ext = EH_W'(MIN_HEIGHT);
		else if (h_ext > EH_W'(MAX_HEIGHT))
			h_ext = EH_W'(MAX_HEIGHT);
		h_new = HEIGHT_W'(h_ext);
	end

	assign div_prod = (EW_W+DIV3_SHIFT)'(w_ext) * (EW_W+DIV3_SHIFT)'(DIV3_RECIP);
	assign band_new = WIDTH_W'(div_prod >> DIV3_SHIFT);
	assign half_new = h_new >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= CFG_W'(RST_FRAME_WIDTH);
			frame_height_q   <= CFG_W'(RST_FRAME_HEIGHT);
			threshold_q      <= THR_W'(RST_THRESHOLD);
			geom_q.w_eff     <= WIDTH_W'(RST_W_EFF);
			geom_q.h_eff     <= HEIGHT_W'(RST_H_EFF);
			geom_q.band1     <= WIDTH_W'(RST_BAND);
			geom_q.band2     <= WIDTH_W'(2 * RST_BAND);
			geom_q.band3     <= WIDTH_W'(3 * RST_BAND);
			geom_q.half1     <= HEIGHT_W'(RST_HALF);
			geom_q.half2     <= HEIGHT_W'(2 * RST_HALF);
			geom_q.threshold <= THR_W'(RST_THRESHOLD);
		end else if (wr_en) begin
			unique case (idx)
				REG_FRAME_WIDTH: begin
					frame_width_q <= pwdata[CFG_W-1:0];
					geom_q.w_eff  <= w_new;
					geom_q.band1  <= band_new;
					geom_q.band2  <= band_new << 1;
					geom_q.band3  <= band_new + (band_new << 1);
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[CFG_W-1:0];
					geom_q.h_eff   <= h_new;
					geom_q.half1   <= half_new;
					geom_q.half2   <= half_new << 1;
				end
				REG_DARK_THRESHOLD: begin
					threshold_q      <= pwdata[THR_W-1:0];
					geom_q.threshold <= pwdata[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FRAME_WIDTH:    prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT:   prdata = DATA_W'(frame_height_q);
			REG_DARK_THRESHOLD: prdata = DATA_W'(threshold_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg = geom_q;

endmodule

// ===== rtl/lbsc_front.sv =====
// Input register with raster position tracking and band placement.
// Depends on lbsc_pkg and lbsc_pixel_if.
module lbsc_front import lbsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	lbsc_pixel_if.sink pixel,
	input  logic   next_ready,
	output s1_t    s1
);

	col_t  col_q;
	row_t  row_q;
	s1_t   s1_q;
	logic  accept;
	band_t band;
	logic  row_in;
	width_t  col_ext;
	width_t  col_inc;
	height_t row_ext;
	height_t row_inc;

	assign pixel.ready = !s1_q.valid || next_ready;
	assign accept      = pixel.valid && pixel.ready;

	assign col_ext = WIDTH_W'(col_q);
	assign col_inc = col_ext + 1'b1;
	assign row_ext = HEIGHT_W'(row_q);
	assign row_inc = row_ext + 1'b1;
	assign row_in  = (row_ext >= cfg.half1) && (row_ext < cfg.half2);

	always_comb begin
		band = BAND_OFF;
		if (row_in) begin
			priority if (col_ext < cfg.band1)
				band = BAND_LEFT;
			else if (col_ext < cfg.band2)
				band = BAND_CENTRE;
			else if (col_ext < cfg.band3)
				band = BAND_RIGHT;
			else
				band = BAND_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pixel.frame_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= cfg.w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= cfg.h_eff) ? '0 : ROW_W'(row_inc);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else begin
			if (pixel.ready)
				s1_q.valid <= pixel.valid;
			if (accept) begin
				s1_q.last  <= pixel.frame_last;
				s1_q.band  <= band;
				s1_q.blue  <= pixel.blue;
				s1_q.green <= pixel.green;
				s1_q.red   <= pixel.red;
			end
		end
	end

	assign s1 = s1_q;

endmodule

// ===== rtl/lbsc_luma.sv =====
// Luma stage: weighted BGR sum, dark test against the threshold, stage register.
// Depends on lbsc_pkg.
module lbsc_luma import lbsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  s1_t  s1,
	input  logic next_ready,
	output logic ready,
	output s2_t  s2
);

	s2_t                   s2_q;
	logic [LUMA_SUM_W-1:0] sum;
	pix_t                  luma;
	logic                  dark;
	logic                  take;

	assign sum = LUMA_SUM_W'(s1.blue) * LUMA_SUM_W'(W_BLUE)
	           + LUMA_SUM_W'(s1.green) * LUMA_SUM_W'(W_GREEN)
	           + LUMA_SUM_W'(s1.red) * LUMA_SUM_W'(W_RED)
	           + LUMA_SUM_W'(LUMA_ROUND);
	assign luma = sum[LUMA_SHIFT+PIX_W-1:LUMA_SHIFT];
	assign dark = luma <= cfg.threshold;

	assign ready = !s2_q.valid || next_ready;
	assign take  = s1.valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q <= '0;
		end else begin
			if (ready)
				s2_q.valid <= s1.valid;
			if (take) begin
				s2_q.last <= s1.last;
				s2_q.band <= dark ? s1.band : BAND_OFF;
			end
		end
	end

	assign s2 = s2_q;

endmodule

// ===== rtl/lbsc_accum.sv =====
// Band totals with saturation, steering decision and the result register.
// Depends on lbsc_pkg and lbsc_result_if.
module lbsc_accum import lbsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  s2_t  s2,
	output logic ready,
	lbsc_result_if.source result
);

	count_t left_q, centre_q, right_q;
	count_t left_n, centre_n, right_n;
	logic   res_valid_q;
	steer_t steer_q;
	count_t res_left_q, res_centre_q, res_right_q;
	logic   res_free;
	logic   go;
	steer_t steer_n;

	function automatic count_t sat_inc(input count_t v, input logic en);
		sat_inc = (en && v != COUNT_MAX) ? v + 1'b1 : v;
	endfunction

	assign res_free = !res_valid_q || result.ready;
	// an item without end of frame never waits on the result register
	assign ready    = !s2.last || res_free;
	assign go       = s2.valid && ready;

	assign left_n   = sat_inc(left_q,   s2.band == BAND_LEFT);
	assign centre_n = sat_inc(centre_q, s2.band == BAND_CENTRE);
	assign right_n  = sat_inc(right_q,  s2.band == BAND_RIGHT);

	always_comb begin
		priority if (centre_n > left_n && centre_n > right_n)
			steer_n = STEER_FORWARD;
		else if (right_n > left_n && right_n > centre_n)
			steer_n = STEER_RIGHT;
		else if (left_n > centre_n && left_n > right_n)
			steer_n = STEER_LEFT;
		else if (left_n == '0 && centre_n == '0 && right_n == '0)
			steer_n = STEER_STOP;
		else
			steer_n = STEER_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			centre_q    <= '0;
			right_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (go) begin
				if (s2.last) begin
					left_q   <= '0;
					centre_q <= '0;
					right_q  <= '0;
				end else begin
					left_q   <= left_n;
					centre_q <= centre_n;
					right_q  <= right_n;
				end
			end
			if (go && s2.last)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && s2.last) begin
			steer_q      <= steer_n;
			res_left_q   <= left_n;
			res_centre_q <= centre_n;
			res_right_q  <= right_n;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.steer        = steer_q;
	assign result.left_count   = res_left_q;
	assign result.centre_count = res_centre_q;
	assign result.right_count  = res_right_q;

endmodule

// ===== rtl/line_band_steering_classifier_top.sv =====
// Top level of the line band steering classifier: register file and pixel pipeline.
// Depends on lbsc_pkg, lbsc_pixel_if, lbsc_result_if, lbsc_cfg, lbsc_front,
// lbsc_luma and lbsc_accum.
//
// Usage
//  - pixel: one BGR pixel per item in raster order; frame_last marks the final
//    pixel of a frame. Rows in the lower half are split into three bands of
//    width/3 columns and dark pixels (luma <= dark_threshold) are counted.
//  - result: one item per frame, on the pixel marked frame_last: the three band
//    counts (saturating at 2^18-1) and the steering command. Counts then clear.
//  - APB: frame_width at 0x0, frame_height at 0x4, dark_threshold at 0x8.
//    Width and height are saturated to the supported range when written.
// Timing
//  - One pixel per cycle sustained outside the result stall below. Three
//    register stages: input/position, luma, totals/result.
//  - A stall on result only holds the pipeline when an end of frame pixel
//    reaches the totals while the previous result is still unread; other
//    pixels keep flowing.
// Reset
//  - arst_n clears position, totals and pipeline valids and restores the
//    register reset values (640 x 480, threshold 60).
module line_band_steering_classifier_top import lbsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	lbsc_pixel_if.sink        pixel,
	lbsc_result_if.source     result
);

	cfg_t cfg;
	s1_t  s1;
	s2_t  s2;
	logic luma_ready;
	logic accum_ready;

	// registers and derived band edges / counted rows
	lbsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// column/row tracking at acceptance; pixel registered with its band
	lbsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pixel      (pixel),
		.next_ready (luma_ready),
		.s1         (s1)
	);

	// luma and dark test
	lbsc_luma u_luma (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s1         (s1),
		.next_ready (accum_ready),
		.ready      (luma_ready),
		.s2         (s2)
	);

	// totals, steering and result register
	lbsc_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.s2     (s2),
		.ready  (accum_ready),
		.result (result)
	);

endmodule

// ===== tb/tb_line_band_steering_classifier_top.sv =====
// Self-checking bench for line_band_steering_classifier_top: streams BGR pixels, mirrors the
// band tallies and steering decision in a local predictor, and checks every result item.
// Depends on lbsc_pkg, lbsc_pixel_if, lbsc_result_if and the top level under test.
module tb_line_band_steering_classifier_top;
	import lbsc_pkg::*;

	// One pixel as queued for the driver
	typedef struct {
		pix_t blue;
		pix_t green;
		pix_t red;
		logic last;
	} pixel_item_t;

	// One end-of-frame report as the block should emit it
	typedef struct {
		steer_t steer;
		count_t left_count;
		count_t centre_count;
		count_t right_count;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	lbsc_pixel_if  pixel_ch ();
	lbsc_result_if result_ch ();

	line_band_steering_classifier_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_ch),
		.result  (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register mirror, as last written (already masked to field width)
	int unsigned width_reg  = 640;
	int unsigned height_reg = 480;
	int unsigned thr_reg    = 60;

	// Mirror of the block's position and running band totals
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned left_tot;
	int unsigned centre_tot;
	int unsigned right_tot;

	pixel_item_t   pending_pixels[$];
	frame_report_t due_reports[$];
	int            pixels_outstanding;
	int            mismatches;
	int            random_items;

	// Effective geometry: registers saturated to the supported range
	function automatic int unsigned eff_width();
		return (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 2) ? 2 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
	endfunction

	// Advance the mirror by one accepted pixel; queue a report on end of frame
	function automatic void tally_pixel(pixel_item_t px);
		int unsigned w;
		int unsigned h;
		int unsigned band;
		int unsigned half;
		int unsigned luma;
		frame_report_t rep;
		w    = eff_width();
		h    = eff_height();
		band = w / 3;
		half = h / 2;
		luma = (1868 * px.blue + 9617 * px.green + 4899 * px.red + 8192) >> 14;
		if (luma <= thr_reg && row_pos >= half && row_pos < 2 * half) begin
			if (col_pos < band)
				left_tot = (left_tot < COUNT_MAX) ? left_tot + 1 : left_tot;
			else if (col_pos < 2 * band)
				centre_tot = (centre_tot < COUNT_MAX) ? centre_tot + 1 : centre_tot;
			else if (col_pos < 3 * band)
				right_tot = (right_tot < COUNT_MAX) ? right_tot + 1 : right_tot;
		end
		if (px.last) begin
			if (centre_tot > left_tot && centre_tot > right_tot)
				rep.steer = STEER_FORWARD;
			else if (right_tot > left_tot && right_tot > centre_tot)
				rep.steer = STEER_RIGHT;
			else if (left_tot > centre_tot && left_tot > right_tot)
				rep.steer = STEER_LEFT;
			else if (left_tot == 0 && centre_tot == 0 && right_tot == 0)
				rep.steer = STEER_STOP;
			else
				rep.steer = STEER_NONE;
			rep.left_count   = count_t'(left_tot);
			rep.centre_count = count_t'(centre_tot);
			rep.right_count  = count_t'(right_tot);
			due_reports.push_back(rep);
			left_tot   = 0;
			centre_tot = 0;
			right_tot  = 0;
			col_pos    = 0;
			row_pos    = 0;
		end else if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	// ---------------------------------------------------------------- driver
	// Bursts of random length with random gaps; now and then a long unbroken run.
	int burst_left = 1;
	int gap_left   = 0;
	pixel_item_t nxt;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (gap_left > 0 || pending_pixels.size() == 0) begin
					pixel_ch.valid <= 1'b0;
					if (gap_left > 0)
						gap_left = gap_left - 1;
				end else begin
					nxt = pending_pixels.pop_front();
					pixel_ch.blue       <= nxt.blue;
					pixel_ch.green      <= nxt.green;
					pixel_ch.red        <= nxt.red;
					pixel_ch.frame_last <= nxt.last;
					pixel_ch.valid      <= 1'b1;
					if (burst_left <= 1) begin
						if ($urandom_range(0, 4) == 0) begin
							burst_left = $urandom_range(64, 200);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 24);
							gap_left   = $urandom_range(0, 4);
						end
					end else begin
						burst_left = burst_left - 1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------- result stalls
	// Segments of always-ready, random ready, and ready one cycle in four.
	int unsigned tick;
	int stall_mode;
	int stall_left;

	always @(posedge clk) begin
		tick = tick + 1;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(16, 160);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_mode)
			0: begin
				result_ch.ready <= 1'b1;
			end
			1: begin
				result_ch.ready <= ($urandom_range(0, 9) < 7);
			end
			default: begin
				result_ch.ready <= (tick % 4 == 0);
			end
		endcase
	end

	pixel_item_t nxt_seen;

	// --------------------------------------------------------------- monitor
	// Predicts on every accepted pixel, checks every accepted result item.
	always @(posedge clk) begin
		frame_report_t want;
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				nxt_seen.blue  = pixel_ch.blue;
				nxt_seen.green = pixel_ch.green;
				nxt_seen.red   = pixel_ch.red;
				nxt_seen.last  = pixel_ch.frame_last;
				tally_pixel(nxt_seen);
				pixels_outstanding = pixels_outstanding - 1;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (due_reports.size() == 0) begin
					$error("result item with no report expected");
					mismatches = mismatches + 1;
				end else begin
					want = due_reports.pop_front();
					if (result_ch.steer !== want.steer) begin
						$error("steer: expected %0d, got %0d", want.steer, result_ch.steer);
						mismatches = mismatches + 1;
					end
					if (result_ch.left_count !== want.left_count) begin
						$error("left_count: expected %0d, got %0d", want.left_count,
							result_ch.left_count);
						mismatches = mismatches + 1;
					end
					if (result_ch.centre_count !== want.centre_count) begin
						$error("centre_count: expected %0d, got %0d", want.centre_count,
							result_ch.centre_count);
						mismatches = mismatches + 1;
					end
					if (result_ch.right_count !== want.right_count) begin
						$error("right_count: expected %0d, got %0d", want.right_count,
							result_ch.right_count);
						mismatches = mismatches + 1;
					end
				end
			end
		end
	end

	// -------------------------------------------------------------- stimulus
	task automatic queue_pixel(input pix_t b, input pix_t g, input pix_t r, input logic last);
		pixel_item_t px;
		px.blue  = b;
		px.green = g;
		px.red   = r;
		px.last  = last;
		pending_pixels.push_back(px);
		pixels_outstanding = pixels_outstanding + 1;
	endtask

	// Mix of near-black, exact black, near-white and fully random pixels
	task automatic queue_random_pixel(input logic last);
		int mode;
		mode = $urandom_range(0, 7);
		case (mode)
			0, 1: queue_pixel(pix_t'($urandom_range(0, 40)), pix_t'($urandom_range(0, 40)),
				pix_t'($urandom_range(0, 40)), last);
			2: queue_pixel(8'd0, 8'd0, 8'd0, last);
			3: queue_pixel(pix_t'($urandom_range(200, 255)), pix_t'($urandom_range(200, 255)),
				pix_t'($urandom_range(200, 255)), last);
			default: queue_pixel(pix_t'($urandom_range(0, 255)),
				pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)), last);
		endcase
	endtask

	// Mostly whole frames; some cut short, some running past a wrap first
	task automatic queue_frame();
		int area;
		int n;
		int pick;
		area = eff_width() * eff_height();
		pick = $urandom_range(0, 19);
		if (pick < 14)
			n = area;
		else if (pick < 17)
			n = $urandom_range(1, area);
		else
			n = area + $urandom_range(1, 2 * area);
		for (int i = 1; i <= n; i++)
			queue_random_pixel(i == n);
		random_items = random_items + n;
	endtask

	// Every pixel accepted and every report seen, then let the pipeline empty
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixels_outstanding != 0 || due_reports.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:    width_reg  = value & 32'h7FF;
			REG_FRAME_HEIGHT:   height_reg = value & 32'h7FF;
			REG_DARK_THRESHOLD: thr_reg    = value & 32'hFF;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
		input logic [DATA_W-1:0] thr);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_DARK_THRESHOLD, thr);
	endtask

	initial begin
		int thr;
		int n;
		pixel_ch.valid      = 1'b0;
		pixel_ch.blue       = '0;
		pixel_ch.green      = '0;
		pixel_ch.red        = '0;
		pixel_ch.frame_last = 1'b0;
		result_ch.ready     = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: row 0 is never counted at 640 x 480, so this is a stop
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);

		// Smallest frame, one column per band, lower row counted only.
		// Row 0 carries dark pixels that must not count.
		configure(3, 2, 127);
		// forward
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		// right
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		// left
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		// tie between left and centre gives no command
		queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);

		// Zero size saturates up to 3 x 2; threshold at top makes every pixel dark.
		// A write to the spare address must change nothing.
		configure(0, 0, 255);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++)
			queue_frame();

		// Widest frame, two rows: a short frame well inside the first row
		configure(2047, 2, $urandom_range(40, 200));
		n = $urandom_range(20, 60);
		for (int i = 1; i <= n; i++)
			queue_random_pixel(i == n);

		// Tallest frame, three columns: a short frame in the upper half
		configure(3, MAX_HEIGHT, $urandom_range(40, 200));
		n = $urandom_range(20, 60);
		for (int i = 1; i <= n; i++)
			queue_random_pixel(i == n);

		// Oversized both ways: short frame, then leave the position mid-row
		configure(2047, 2047, 0);
		for (int i = 1; i <= 5; i++)
			queue_random_pixel(i == 5);
		for (int i = 0; i < 4; i++)
			queue_random_pixel(1'b0);

		// Junk above the width field; the stale column must wrap on the smaller frame
		configure(32'hFFFF_F805, $urandom_range(2, 6), $urandom_range(30, 200));
		for (int i = 0; i < 3; i++)
			queue_frame();

		// Random small geometries and thresholds, extremes now and then
		random_items = 0;
		while (random_items < 400) begin
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 255;
				default: thr = $urandom_range(30, 200);
			endcase
			configure($urandom_range(3, 9), $urandom_range(2, 5), thr);
			repeat ($urandom_range(2, 5))
				queue_frame();
			// sometimes end the phase mid-frame so the next geometry sees a stale position
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 12))
					queue_random_pixel(1'b0);
		end

		wait_drained();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule
